// File: design/cbjq_pkg.sv
package cbjq_pkg;

  // fixed field widths of the job and result beats
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 3;
  localparam int TAG_OUT_W  = 32;
  localparam int COST_W     = 64;
  localparam int ITEMS_W    = 16;
  localparam int CNT_OUT_W  = 6;
  localparam int TOTAL_W    = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ENQ        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RUN        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DRAIN_DONE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE_DONE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_CLOSE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              enq_write;   // store job at tail
    logic              start;       // latch drain limits, clear run sums
    logic              set_closed;
    logic              pop;         // advance head
    logic              step_run;    // count a run job
    logic              load_out;    // load result register
    logic [KIND_W-1:0] kind;
    logic              accepted;
    logic              last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic occ_zero;
    logic full;
    logic closed;
    logic fits;
    logic limit_ok;
    logic head_cancel;
  } dp_stat_t;

endpackage

// File: design/cbjq_dp.sv
module cbjq_dp
  import cbjq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [TAG_OUT_W-1:0]  in_job_tag,
  input  logic [COST_W-1:0]     in_job_cost,
  input  logic                  in_has_cancel,
  input  logic [ITEMS_W-1:0]    in_max_items,
  input  logic [COST_W-1:0]     in_max_cost,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_result_kind,
  output logic [TAG_OUT_W-1:0]  out_tag,
  output logic                  out_accepted,
  output logic [CNT_OUT_W-1:0]  out_run_count,
  output logic [CNT_OUT_W-1:0]  out_pending_count,
  output logic [TOTAL_W-1:0]    out_submitted_total,
  output logic [TOTAL_W-1:0]    out_drained_total,
  output logic                  out_last
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int STW    = (TAG_WIDTH < TAG_OUT_W) ? TAG_WIDTH : TAG_OUT_W;
  localparam int ENT_W  = STW + COST_W + 1;

  logic [ENT_W-1:0]   mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]   rd_r;

  logic [PTR_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic               closed_r, closed_nxt;
  logic [TOTAL_W-1:0] sub_r, sub_nxt, drn_r, drn_nxt;
  logic [OCC_W-1:0]   count_r, count_nxt;
  logic [COST_W-1:0]  sum_r, sum_nxt;
  logic [ITEMS_W-1:0] limit_r, limit_nxt;
  logic [COST_W-1:0]  budget_r, budget_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [KIND_W-1:0]    kind_r;
  logic [TAG_OUT_W-1:0] tag_r;
  logic                 acc_r, last_r;
  logic [CNT_OUT_W-1:0] runs_r, pend_r;
  logic [TOTAL_W-1:0]   subo_r, drno_r;

  logic [STW-1:0]     head_tag;
  logic [COST_W-1:0]  head_cost;
  logic               head_cancel;
  logic [COST_W:0]    sum_ext;
  logic [COST_W-1:0]  sum_sat;
  logic               unlimited;

  assign head_tag    = rd_r[ENT_W-1 -: STW];
  assign head_cost   = rd_r[COST_W:1];
  assign head_cancel = rd_r[0];

  // saturating running cost and budget check
  assign sum_ext   = {1'b0, sum_r} + {1'b0, head_cost};
  assign sum_sat   = sum_ext[COST_W] ? {COST_W{1'b1}} : sum_ext[COST_W-1:0];
  assign unlimited = &budget_r;

  always_comb begin
    stat.slot_free   = !out_valid_r || out_ready;
    stat.occ_zero    = (occ_r == '0);
    stat.full        = (occ_r == OCC_W'(QUEUE_DEPTH));
    stat.closed      = closed_r;
    stat.fits        = unlimited || (head_cost == '0) || (sum_sat <= budget_r) ||
                       ((count_r == '0) && (budget_r != '0));
    stat.limit_ok    = (limit_r == '0) || (ITEMS_W'(count_r) < limit_r);
    stat.head_cancel = head_cancel;
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    if (cmd.pop) begin
      head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (cmd.enq_write) begin
      tail_nxt = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    occ_nxt    = occ_r + OCC_W'(cmd.enq_write) - OCC_W'(cmd.pop);
    closed_nxt = closed_r | cmd.set_closed;
    sub_nxt    = sub_r + TOTAL_W'(cmd.enq_write);
    drn_nxt    = drn_r + TOTAL_W'(cmd.step_run);
    limit_nxt  = cmd.start ? in_max_items : limit_r;
    budget_nxt = cmd.start ? in_max_cost : budget_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    if (cmd.start) begin
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (cmd.step_run) begin
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_sat;
    end
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      closed_r    <= 1'b0;
      sub_r       <= '0;
      drn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      closed_r    <= closed_nxt;
      sub_r       <= sub_nxt;
      drn_r       <= drn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // drain scratch state
  always_ff @(posedge clk) begin
    count_r  <= count_nxt;
    sum_r    <= sum_nxt;
    limit_r  <= limit_nxt;
    budget_r <= budget_nxt;
  end

  // job store, read port follows the next head
  always_ff @(posedge clk) begin
    if (cmd.enq_write) begin
      mem[tail_r] <= {in_job_tag[STW-1:0], in_job_cost, in_has_cancel};
    end
    rd_r <= mem[head_nxt];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind_r <= cmd.kind;
      tag_r  <= ((cmd.kind == KIND_RUN) || (cmd.kind == KIND_CANCEL)) ?
                TAG_OUT_W'(head_tag) : '0;
      acc_r  <= cmd.accepted;
      runs_r <= (cmd.kind == KIND_DRAIN_DONE) ? CNT_OUT_W'(count_r) : '0;
      pend_r <= CNT_OUT_W'(occ_nxt);
      subo_r <= sub_nxt;
      drno_r <= drn_nxt;
      last_r <= cmd.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_tag             = tag_r;
  assign out_accepted        = acc_r;
  assign out_run_count       = runs_r;
  assign out_pending_count   = pend_r;
  assign out_submitted_total = subo_r;
  assign out_drained_total   = drno_r;
  assign out_last            = last_r;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (occ_r != '0))
    else $error("pop from empty queue");
  a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_write |-> (!closed_r && (occ_r != OCC_W'(QUEUE_DEPTH))))
    else $error("store into full or closed queue");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r)
    else $error("closed queue reopened");
`endif

endmodule

// File: design/cbjq_ctrl.sv
module cbjq_ctrl
  import cbjq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  state_t state_r, state_nxt;
  logic   take;

  assign in_ready = (state_r == ST_IDLE) && stat.slot_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take && (in_command == CMD_DRAIN)) begin
          state_nxt = ST_DRAIN;
        end else if (take && (in_command == CMD_CLOSE)) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_DRAIN: begin
        if (stat.slot_free &&
            !(!stat.occ_zero && stat.limit_ok && stat.fits)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (stat.slot_free && stat.occ_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          case (in_command)
            CMD_ENQ: begin
              cmd.enq_write = !stat.closed && !stat.full;
              cmd.accepted  = !stat.closed && !stat.full;
              cmd.load_out  = 1'b1;
              cmd.kind      = KIND_ENQ;
              cmd.last      = 1'b1;
            end
            CMD_DRAIN: cmd.start = 1'b1;
            CMD_CLOSE: cmd.set_closed = 1'b1;
            default: cmd = '0;
          endcase
        end
      end
      ST_DRAIN: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          if (!stat.occ_zero && stat.limit_ok && stat.fits) begin
            cmd.pop      = 1'b1;
            cmd.step_run = 1'b1;
            cmd.kind     = KIND_RUN;
          end else begin
            cmd.kind = KIND_DRAIN_DONE;
            cmd.last = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        if (stat.slot_free) begin
          if (!stat.occ_zero) begin
            cmd.pop      = 1'b1;
            cmd.load_out = stat.head_cancel;
            cmd.kind     = KIND_CANCEL;
          end else begin
            cmd.load_out = 1'b1;
            cmd.kind     = KIND_CLOSE_DONE;
            cmd.last     = 1'b1;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken during a queue walk");
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_command == CMD_CLOSE)) |=> (state_r == ST_CLOSE))
    else $error("close did not start a flush");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.last && (state_r != ST_IDLE)) |=> (state_r == ST_IDLE))
    else $error("walk continued after final beat");
`endif

endmodule

// File: design/cost_budgeted_job_queue.sv
// cost budgeted job queue
// input channel in_valid/in_ready carries one command beat: enqueue a job
// (tag, cost, cancel flag), drain under an item limit and a cost budget, or
// close and flush. results leave on out_valid/out_ready, one beat per result,
// out_last marking the final beat of a command.
// enqueue: the reply beat is loaded into the result register on acceptance;
// with the receiver ready a new enqueue is taken every cycle.
// drain: the sequencer enters the drain walk after acceptance, then one run
// beat per cycle while the receiver is ready, from the head of the queue, then
// a drain done beat; the synchronous read port of the job store, addressed by
// the next head, sets this one entry per cycle walk.
// close: each queued entry is popped in turn (entries without the cancel flag are
// dropped silently), then the close done beat. no new command is taken while
// a drain or close walks the queue.
// reset clears pointers, occupancy, closed flag and totals; the job store is
// not cleared, so no clearing pass is needed.
// a stalled receiver holds the current result in the output register and the
// walk waits; nothing is lost or repeated.
module cost_budgeted_job_queue
  import cbjq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_WIDTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [TAG_OUT_W-1:0] in_job_tag,
  input  logic [COST_W-1:0]    in_job_cost,
  input  logic                 in_has_cancel,
  input  logic [ITEMS_W-1:0]   in_max_items,
  input  logic [COST_W-1:0]    in_max_cost,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [TAG_OUT_W-1:0] out_tag,
  output logic                 out_accepted,
  output logic [CNT_OUT_W-1:0] out_run_count,
  output logic [CNT_OUT_W-1:0] out_pending_count,
  output logic [TOTAL_W-1:0]   out_submitted_total,
  output logic [TOTAL_W-1:0]   out_drained_total,
  output logic                 out_last
);

  // commands from the sequencer, status back from the queue datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: idle, drain walk, close walk
  cbjq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  // job store, pointers, totals, budget check and result register
  cbjq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_job_tag          (in_job_tag),
    .in_job_cost         (in_job_cost),
    .in_has_cancel       (in_has_cancel),
    .in_max_items        (in_max_items),
    .in_max_cost         (in_max_cost),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_tag             (out_tag),
    .out_accepted        (out_accepted),
    .out_run_count       (out_run_count),
    .out_pending_count   (out_pending_count),
    .out_submitted_total (out_submitted_total),
    .out_drained_total   (out_drained_total),
    .out_last            (out_last)
  );

endmodule
